// ===== design/rfce_pkg.sv =====
package rfce_pkg;

    localparam int FRAME_LEN = 9;
    localparam int CNT_W     = 7;

    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t ID_FIRST_IDX = cnt_t'(3);
    localparam cnt_t ID_LAST_IDX  = cnt_t'(6);
    localparam cnt_t CRC_LAST_IDX = cnt_t'(FRAME_LEN - 3);
    localparam cnt_t RX_LOW_IDX   = cnt_t'(FRAME_LEN - 2);
    localparam cnt_t FINAL_IDX    = cnt_t'(FRAME_LEN - 1);
    localparam int   ID_BYTES     = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [31:0] ID_FAIL  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        logic [31:0] card_id;
        logic        crc_ok;
        logic [15:0] crc_computed;
    } result_t;

    // Reflected CRC-16/MODBUS, one byte, bit loop unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] nibble_swap(input logic [7:0] b);
        return {b[3:0], b[7:4]};
    endfunction

endpackage

// ===== design/rfid_frame_crc_id_extract_core.sv =====
// Bytes go to the input register; a final byte's result then loads the result register.
// Throughput: one byte per cycle, but a final byte stalls only while the result
// register holds an untaken result; the CRC byte step is a single pass of XOR logic.
// Reset: synchronous, active-low aresetn; frame idle, CRC at 0xFFFF, both stages empty.
module rfid_frame_crc_id_extract_core
    import rfce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_card_id,
    output logic        m_crc_ok,
    output logic [15:0] m_crc_computed
);

    logic    advance;
    logic    item_valid;
    item_t   item;
    logic    out_free;
    logic    res_valid;
    result_t res;

    rfce_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_start (s_frame_start),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    rfce_frame_proc u_proc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    rfce_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (res_valid),
        .res            (res),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_card_id      (m_card_id),
        .m_crc_ok       (m_crc_ok),
        .m_crc_computed (m_crc_computed)
    );

endmodule

// ===== design/rfce_in_stage.sv =====
module rfce_in_stage
    import rfce_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_frame_start,
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.data_byte   <= s_data_byte;
            item_reg.frame_start <= s_frame_start;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/rfce_frame_proc.sv =====
module rfce_frame_proc
    import rfce_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_valid,
    input  item_t   item,
    input  logic    out_free,
    output logic    advance,
    output logic    res_valid,
    output result_t res
);

    logic [15:0] crc_reg,      crc_next;
    cnt_t        byte_cnt_reg, byte_cnt_next;
    logic [31:0] id_reg,       id_next;
    logic [7:0]  rx_low_reg,   rx_low_next;
    logic        active_reg,   active_next;

    logic [15:0] crc_base;
    cnt_t        idx;
    logic [31:0] id_base;
    logic [7:0]  rx_low_base;
    logic        take;
    logic        is_final;
    logic [7:0]  swapped;

    always_comb begin
        take        = item.frame_start || active_reg;
        crc_base    = item.frame_start ? CRC_INIT : crc_reg;
        idx         = item.frame_start ? '0 : byte_cnt_reg;
        id_base     = item.frame_start ? '0 : id_reg;
        rx_low_base = item.frame_start ? '0 : rx_low_reg;
        swapped     = nibble_swap(item.data_byte);
        is_final    = take && (idx == FINAL_IDX);

        crc_next = (idx <= CRC_LAST_IDX) ? crc16_byte(crc_base, item.data_byte) : crc_base;

        id_next = id_base;
        for (int k = 0; k < ID_BYTES; k++) begin
            if (idx == ID_FIRST_IDX + cnt_t'(k)) begin
                id_next[k*8 +: 8] = id_base[k*8 +: 8] | swapped;
            end
        end

        rx_low_next = (idx == RX_LOW_IDX) ? item.data_byte : rx_low_base;

        if (is_final) begin
            byte_cnt_next = '0;
            active_next   = 1'b0;
        end else begin
            byte_cnt_next = idx + cnt_t'(1);
            active_next   = 1'b1;
        end

        res.crc_computed = crc_next;
        res.crc_ok       = ({item.data_byte, rx_low_base} == crc_next);
        res.card_id      = res.crc_ok ? id_next : ID_FAIL;
    end

    // A final byte waits for room in the result register; others never stall.
    assign advance   = item_valid && (out_free || !is_final);
    assign res_valid = item_valid && is_final && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CRC_INIT;
            byte_cnt_reg <= '0;
            id_reg       <= '0;
            rx_low_reg   <= '0;
            active_reg   <= 1'b0;
        end else if (advance && take) begin
            crc_reg      <= crc_next;
            byte_cnt_reg <= byte_cnt_next;
            id_reg       <= id_next;
            rx_low_reg   <= rx_low_next;
            active_reg   <= active_next;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_cnt_reg <= FINAL_IDX)
        else $error("byte count past frame end");

    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> byte_cnt_reg == '0)
        else $error("byte count nonzero while idle");

    a_final_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> !active_reg && byte_cnt_reg == '0)
        else $error("frame still active after result");

    a_no_stray: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (active_reg || item.frame_start))
        else $error("result from idle byte");

endmodule

// ===== design/rfce_out_stage.sv =====
module rfce_out_stage
    import rfce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res,
    output logic        out_free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_card_id,
    output logic        m_crc_ok,
    output logic [15:0] m_crc_computed
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_card_id      = res_reg.card_id;
    assign m_crc_ok       = res_reg.crc_ok;
    assign m_crc_computed = res_reg.crc_computed;

endmodule
